[rtl/ehpe_pkg.sv]
// Shared types, constants and helpers for the hex pixel encoder.
// No dependencies; every other file in rtl/ refers to this package by scoped name.
package ehpe_pkg;

    // Geometry and text layout
    localparam int MAX_WIDTH       = 4096;
    localparam int COL_W           = $clog2(MAX_WIDTH);
    localparam int WIDTH_W         = 13;
    localparam int PIX_PER_LINE    = 13;
    localparam int MASK_PER_LINE   = 78;
    localparam int ALPHA_CLEAR_MAX = 32;
    localparam int POL_W           = 4;
    localparam int MCL_W           = 7;
    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = $clog2(QDEPTH);

    // Configuration register indexes
    localparam int CFG_IDX_W           = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MASK_ENABLE = 2'd1;

    // Stream codes and special characters
    localparam logic STREAM_IMAGE = 1'b0;
    localparam logic STREAM_MASK  = 1'b1;
    localparam logic [7:0] CHAR_NL   = 8'd10;
    localparam logic [7:0] CHAR_ZERO = 8'h30;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       first_pixel;
    } t_pixel;

    typedef struct packed {
        logic       stream;
        logic [7:0] character;
        logic       last;
    } t_result;

    // Which optional characters a pixel adds after its six image digits
    typedef struct packed {
        logic       img_nl;
        logic       m_emit;
        logic [3:0] m_char;
        logic       m_pad;
        logic       m_nl;
    } t_mark;

    typedef struct packed {
        t_mark      mark;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } t_job;

    // Uppercase ASCII hex digit
    function automatic logic [7:0] hex_char(input logic [3:0] v);
        logic [7:0] w;
        w = {4'h0, v};
        return (v < 4'd10) ? (CHAR_ZERO + w) : (8'h37 + w);
    endfunction

    // Exact floor(x / 255) for x up to 255*255
    function automatic logic [7:0] div255(input logic [15:0] x);
        logic [16:0] s;
        s = {1'b0, x} + {9'h000, x[15:8]} + 17'd1;
        return s[15:8];
    endfunction

endpackage

[rtl/eps_hex_pixel_encoder_top.sv]
// Top level of the hex pixel encoder: front end, job queue, character sequencer.
// Depends on ehpe_pkg, ehpe_front, ehpe_queue and ehpe_back.
//
//  channel  | handshake            | word
//  ---------+----------------------+------------------------------------------
//  pixel in | push / full          | i_pixel  (red, green, blue, alpha, first)
//  result   | pop / empty          | o_result (stream, character, last)
//  config   | cfg_valid / cfg_ready| i_cfg_index, i_cfg_data (always ready)
//
// Each pixel yields 6 to 10 characters, one per cycle from the sequencer while
// the result register is empty or being popped; the front end blends in two
// stages and runs ahead by up to four queued pixels plus its stage register.
// Reset is synchronous; afterwards pixels are taken at once (no clearing pass).
// A stalled result stalls only the sequencer; the front fills until the queue is full.
module eps_hex_pixel_encoder_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           push,
    output logic                           full,
    input  ehpe_pkg::t_pixel               i_pixel,
    output logic                           empty,
    input  logic                           pop,
    output ehpe_pkg::t_result              o_result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ehpe_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [ehpe_pkg::WIDTH_W-1:0]   i_cfg_data
);

    logic           f_valid;
    ehpe_pkg::t_job f_job;
    logic           q_full;
    logic           q_valid;
    ehpe_pkg::t_job q_job;
    logic           q_rd;

    // Take and classify pixels
    ehpe_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_pixel     (i_pixel),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_job_valid (f_valid),
        .o_job       (f_job),
        .i_job_full  (q_full)
    );

    // Buffer jobs
    ehpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (f_valid),
        .i_job   (f_job),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_job   (q_job),
        .i_rd    (q_rd)
    );

    // Emit characters
    ehpe_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_done  (q_rd),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result)
    );

endmodule

[rtl/ehpe_front.sv]
// Front end: takes pixels, holds configuration and counters, blends over white.
// Depends on ehpe_pkg; feeds ehpe_queue with one job word per pixel.
module ehpe_front (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  ehpe_pkg::t_pixel                i_pixel,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [ehpe_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [ehpe_pkg::WIDTH_W-1:0]    i_cfg_data,
    output logic                            o_job_valid,
    output ehpe_pkg::t_job                  o_job,
    input  logic                            i_job_full
);

    // Configuration
    logic [ehpe_pkg::WIDTH_W-1:0] r_width;
    logic                         r_mask_en;

    // Counters
    logic [ehpe_pkg::POL_W-1:0] r_pol, n_pol;
    logic [ehpe_pkg::COL_W-1:0] r_col, n_col;
    logic [3:0]                 r_nib, n_nib;
    logic [ehpe_pkg::MCL_W-1:0] r_mcl, n_mcl;

    // Stage register
    logic           r_fv;
    logic [15:0]    r_xr, r_xg, r_xb;
    ehpe_pkg::t_mark r_mark, n_mark;
    logic [15:0]    n_xr, n_xg, n_xb;

    logic accept;
    logic [ehpe_pkg::POL_W-1:0] pol;
    logic [ehpe_pkg::COL_W-1:0] col;
    logic [3:0]                 nib, nib_set;
    logic [ehpe_pkg::MCL_W-1:0] mcl, mcl1, mcl2;
    logic [ehpe_pkg::WIDTH_W-1:0] weff, col_inc;
    logic row_end, emit, pad;
    logic [7:0] inv;
    logic [15:0] white;

    assign cfg_ready   = 1'b1;
    assign full        = r_fv & i_job_full;
    assign accept      = push & ~full;
    assign o_job_valid = r_fv;

    // Finish the blend on the way into the queue
    always_comb begin
        o_job.mark  = r_mark;
        o_job.red   = ehpe_pkg::div255(r_xr);
        o_job.green = ehpe_pkg::div255(r_xg);
        o_job.blue  = ehpe_pkg::div255(r_xb);
    end

    // Blend numerators: c*a + 255*(255-a)
    always_comb begin
        inv   = 8'hFF - i_pixel.alpha;
        white = {inv, 8'h00} - {8'h00, inv};
        n_xr  = ({8'h00, i_pixel.red}   * {8'h00, i_pixel.alpha}) + white;
        n_xg  = ({8'h00, i_pixel.green} * {8'h00, i_pixel.alpha}) + white;
        n_xb  = ({8'h00, i_pixel.blue}  * {8'h00, i_pixel.alpha}) + white;
    end

    // Classify the pixel and advance the counters
    always_comb begin
        pol = i_pixel.first_pixel ? '0 : r_pol;
        col = i_pixel.first_pixel ? '0 : r_col;
        nib = i_pixel.first_pixel ? '0 : r_nib;
        mcl = i_pixel.first_pixel ? '0 : r_mcl;

        n_mark.img_nl = (pol == ehpe_pkg::POL_W'(ehpe_pkg::PIX_PER_LINE - 1));
        n_pol = n_mark.img_nl ? '0 : pol + 1'b1;

        if ((r_width == '0) || (r_width > ehpe_pkg::WIDTH_W'(ehpe_pkg::MAX_WIDTH))) begin
            weff = ehpe_pkg::WIDTH_W'(ehpe_pkg::MAX_WIDTH);
        end else begin
            weff = r_width;
        end
        col_inc = {1'b0, col} + 1'b1;
        row_end = (col_inc == weff) ||
                  (col == ehpe_pkg::COL_W'(ehpe_pkg::MAX_WIDTH - 1));
        n_col   = row_end ? '0 : col_inc[ehpe_pkg::COL_W-1:0];

        nib_set = (i_pixel.alpha <= 8'(ehpe_pkg::ALPHA_CLEAR_MAX)) ?
                  (nib | (4'b1000 >> col[1:0])) : nib;
        emit = r_mask_en & ((col[1:0] == 2'd3) | row_end);
        mcl1 = mcl + 1'b1;
        pad  = row_end & mcl1[0];
        mcl2 = mcl1 + {{(ehpe_pkg::MCL_W-1){1'b0}}, pad};

        n_mark.m_emit = emit;
        n_mark.m_char = nib_set;
        n_mark.m_pad  = emit & pad;
        n_mark.m_nl   = emit & (mcl2 >= ehpe_pkg::MCL_W'(ehpe_pkg::MASK_PER_LINE));

        if (!r_mask_en) begin
            n_nib = nib;
            n_mcl = mcl;
        end else if (emit) begin
            n_nib = '0;
            n_mcl = n_mark.m_nl ? '0 : mcl2;
        end else begin
            n_nib = nib_set;
            n_mcl = mcl;
        end
    end

    // Hold configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= ehpe_pkg::WIDTH_W'(1);
            r_mask_en <= 1'b0;
        end else if (cfg_valid && cfg_ready) begin
            if (i_cfg_index == ehpe_pkg::CFG_IMAGE_WIDTH) begin
                r_width <= i_cfg_data;
            end else if (i_cfg_index == ehpe_pkg::CFG_MASK_ENABLE) begin
                r_mask_en <= i_cfg_data[0];
            end
        end
    end

    // Advance counters and the stage register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pol <= '0;
            r_col <= '0;
            r_nib <= '0;
            r_mcl <= '0;
            r_fv  <= 1'b0;
        end else begin
            if (accept) begin
                r_pol <= n_pol;
                r_col <= n_col;
                r_nib <= n_nib;
                r_mcl <= n_mcl;
                r_fv  <= 1'b1;
            end else if (r_fv && !i_job_full) begin
                r_fv <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_xr   <= n_xr;
            r_xg   <= n_xg;
            r_xb   <= n_xb;
            r_mark <= n_mark;
        end
    end

    a_pol_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pol < ehpe_pkg::POL_W'(ehpe_pkg::PIX_PER_LINE))
        else $error("image pixel count out of range");

    a_mcl_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mcl < ehpe_pkg::MCL_W'(ehpe_pkg::MASK_PER_LINE))
        else $error("mask character count out of range");

endmodule

[rtl/ehpe_queue.sv]
// Short job queue between front end and character sequencer.
// Depends on ehpe_pkg for the job word type and depth.
module ehpe_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_wr,
    input  ehpe_pkg::t_job i_job,
    output logic           o_full,
    output logic           o_valid,
    output ehpe_pkg::t_job o_job,
    input  logic           i_rd
);

    ehpe_pkg::t_job r_mem [ehpe_pkg::QDEPTH];
    logic [ehpe_pkg::QPTR_W-1:0] r_wp, r_rp;
    logic [ehpe_pkg::QPTR_W:0]   r_cnt;
    logic do_wr, do_rd;

    assign o_full  = (r_cnt == (ehpe_pkg::QPTR_W+1)'(ehpe_pkg::QDEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rp];
    assign do_wr   = i_wr & ~o_full;
    assign do_rd   = i_rd & o_valid;

    // Store the word
    always_ff @(posedge i_clk) begin
        if (do_wr) begin
            r_mem[r_wp] <= i_job;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_wr) begin
                r_wp <= r_wp + 1'b1;
            end
            if (do_rd) begin
                r_rp <= r_rp + 1'b1;
            end
            if (do_wr && !do_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (do_rd && !do_wr) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (ehpe_pkg::QPTR_W+1)'(ehpe_pkg::QDEPTH))
        else $error("queue count above depth");

endmodule

[rtl/ehpe_back.sv]
// Character sequencer: walks each job's character slots, one per cycle unless the result stalls.
// Depends on ehpe_pkg; reads ehpe_queue's head and drives the result register.
module ehpe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  ehpe_pkg::t_job    i_job,
    output logic              o_job_done,
    output logic              empty,
    input  logic              pop,
    output ehpe_pkg::t_result o_result
);

    // Slot codes in output order
    localparam logic [3:0] SLOT_R_HI  = 4'd0;
    localparam logic [3:0] SLOT_R_LO  = 4'd1;
    localparam logic [3:0] SLOT_G_HI  = 4'd2;
    localparam logic [3:0] SLOT_G_LO  = 4'd3;
    localparam logic [3:0] SLOT_B_HI  = 4'd4;
    localparam logic [3:0] SLOT_B_LO  = 4'd5;
    localparam logic [3:0] SLOT_I_NL  = 4'd6;
    localparam logic [3:0] SLOT_M_HEX = 4'd7;
    localparam logic [3:0] SLOT_M_PAD = 4'd8;
    localparam logic [3:0] SLOT_M_NL  = 4'd9;
    localparam int NSLOT = 10;

    logic [3:0]        r_slot;
    logic              r_ovalid;
    ehpe_pkg::t_result r_out, n_out;
    logic [NSLOT-1:0]  en;
    logic [3:0]        nxt;
    logic              found;
    logic              step;

    assign empty      = ~r_ovalid;
    assign o_result   = r_out;
    assign step       = i_job_valid & (~r_ovalid | pop);
    assign o_job_done = step & ~found;

    // Find the next slot this job uses
    always_comb begin
        en = {i_job.mark.m_nl, i_job.mark.m_pad, i_job.mark.m_emit,
              i_job.mark.img_nl, 6'h3F};
        nxt   = SLOT_R_HI;
        found = 1'b0;
        for (int i = NSLOT - 1; i >= 0; i--) begin
            if ((4'(i) > r_slot) && en[i]) begin
                nxt   = 4'(i);
                found = 1'b1;
            end
        end
    end

    // Pick the character for the current slot
    always_comb begin
        n_out.stream    = ehpe_pkg::STREAM_IMAGE;
        n_out.last      = ~found;
        case (r_slot)
            SLOT_R_HI:  n_out.character = ehpe_pkg::hex_char(i_job.red[7:4]);
            SLOT_R_LO:  n_out.character = ehpe_pkg::hex_char(i_job.red[3:0]);
            SLOT_G_HI:  n_out.character = ehpe_pkg::hex_char(i_job.green[7:4]);
            SLOT_G_LO:  n_out.character = ehpe_pkg::hex_char(i_job.green[3:0]);
            SLOT_B_HI:  n_out.character = ehpe_pkg::hex_char(i_job.blue[7:4]);
            SLOT_B_LO:  n_out.character = ehpe_pkg::hex_char(i_job.blue[3:0]);
            SLOT_I_NL:  n_out.character = ehpe_pkg::CHAR_NL;
            SLOT_M_HEX: begin
                n_out.stream    = ehpe_pkg::STREAM_MASK;
                n_out.character = ehpe_pkg::hex_char(i_job.mark.m_char);
            end
            SLOT_M_PAD: begin
                n_out.stream    = ehpe_pkg::STREAM_MASK;
                n_out.character = ehpe_pkg::CHAR_ZERO;
            end
            SLOT_M_NL: begin
                n_out.stream    = ehpe_pkg::STREAM_MASK;
                n_out.character = ehpe_pkg::CHAR_NL;
            end
            default:    n_out.character = ehpe_pkg::CHAR_NL;
        endcase
    end

    // Advance the slot and load the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= SLOT_R_HI;
            r_ovalid <= 1'b0;
        end else begin
            if (step) begin
                r_slot   <= found ? nxt : SLOT_R_HI;
                r_ovalid <= 1'b1;
            end else if (pop) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out <= n_out;
        end
    end

    a_slot_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_job_valid |-> en[r_slot[3:0]])
        else $error("sequencer on a slot the job does not use");

    a_slot_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_job_valid |-> (r_slot == SLOT_R_HI))
        else $error("sequencer left mid-job without a job");

endmodule
